/* src/ecal_pkg.sv */
// Shared types, constants and the month table for the epoch-to-calendar pipeline.
// Used by ecal_day_split, ecal_fields and epoch_seconds_to_calendar; no dependencies.
package ecal_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LOCAL_MODE = 2'd0,
    REG_ZONE_OFFSET = 2'd1,
    REG_ZONE_KNOWN = 2'd2
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Time constants
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  localparam logic [15:0] DAYS_PER_CYCLE = 16'd1461;  // four years, first one leap
  localparam logic [15:0] DAYS_PER_WEEK  = 16'd7;

  // Day 0 is 1970-01-01; the four-year cycles start at 1968-01-01
  localparam logic [15:0] EPOCH_TO_CYCLE_DAYS = 16'd731;
  // 2100-03-01: from here on a virtual Feb 29 of 2100 is inserted
  localparam logic [15:0] DAY_2100_MAR1 = 16'd47541;
  localparam logic [7:0]  YEAR_2100 = 8'd200;
  localparam logic [7:0]  CYCLE_BASE_YEAR = 8'd68;
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;        // Thursday

  // Reciprocals for constant division (floor(2^k / divisor))
  localparam logic [22:0] DAY128_RECIP = 23'd6362914;   // 2^32 / 675
  localparam logic [13:0] CYCLE_RECIP  = 14'd11483;     // 2^24 / 1461
  localparam logic [21:0] WEEK_RECIP   = 22'd2396745;   // 2^24 / 7
  localparam logic [12:0] HOUR_RECIP   = 13'd4660;      // 2^24 / 3600
  localparam logic [14:0] MIN_RECIP    = 15'd17477;     // ceil(2^20 / 60), exact below 3600

  // Item passed from ecal_day_split to ecal_fields: day count, seconds of day and flags
  typedef struct packed {
    logic [15:0] days;
    logic [16:0] rem;
    logic        local_mode;
    logic        fail;
  } day_item_t;

  typedef struct packed {
    logic       ok;
    logic       dst_flag;
    logic [2:0] weekday;
    logic [8:0] year_day;
    logic [7:0] years_since_1900;
    logic [3:0] month;
    logic [4:0] month_day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } result_t;

  // First day of year of a month (0 = January)
  function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'((leap && (mon >= 4'd2)) ? 1 : 0);
  endfunction

endpackage

/* src/ecal_day_split.sv */
// Front three pipeline stages: zone shift, then split of seconds into days and
// seconds of day. Depends on ecal_pkg.
module ecal_day_split (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_epoch,
  input  logic                  local_mode,
  input  logic [11:0]           zone_offset,
  input  logic                  zone_known,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ecal_pkg::day_item_t   out_item
);
  import ecal_pkg::*;

  logic [2:0] v_r;
  logic [2:0] en;

  // stage 0: shifted time
  logic [31:0] s0_t_r, s0_t_nxt;
  logic        s0_local_r, s0_fail_r;
  // stage 1: approximate day count
  logic [15:0] s1_q_r, s1_q_nxt;
  logic [31:0] s1_t_r;
  logic        s1_local_r, s1_fail_r;
  // stage 2: corrected day count and seconds of day
  logic [15:0] s2_days_r, s2_days_nxt;
  logic [16:0] s2_rem_r, s2_rem_nxt;
  logic        s2_local_r, s2_fail_r;

  logic signed [31:0] off_ext;
  logic signed [31:0] off_secs;
  logic [47:0]        prod1;
  logic [31:0]        q_secs;
  logic [17:0]        rem0;

  // A stage takes a new item when it is empty or its item moves on
  always_comb begin
    en[2] = !v_r[2] || out_ready;
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[2];

  // Offset in seconds: minutes * 60 as two shifts
  always_comb begin
    off_ext  = 32'(signed'(zone_offset));
    off_secs = (off_ext <<< 6) - (off_ext <<< 2);
    s0_t_nxt = in_epoch + (local_mode ? 32'(off_secs) : 32'd0);
  end

  // t / 86400 = (t >> 7) / 675, reciprocal may fall one short
  always_comb begin
    prod1    = 48'(s0_t_r[31:7]) * 48'(DAY128_RECIP);
    s1_q_nxt = prod1[47:32];
  end

  // One correction step
  always_comb begin
    q_secs = 32'(s1_q_r) * SECS_PER_DAY;
    rem0   = 18'(s1_t_r - q_secs);
    if (rem0 >= 18'(SECS_PER_DAY)) begin
      s2_days_nxt = s1_q_r + 16'd1;
      s2_rem_nxt  = 17'(rem0 - 18'(SECS_PER_DAY));
    end else begin
      s2_days_nxt = s1_q_r;
      s2_rem_nxt  = rem0[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_t_r     <= s0_t_nxt;
      s0_local_r <= local_mode;
      s0_fail_r  <= local_mode && !zone_known;
    end
    if (en[1]) begin
      s1_q_r     <= s1_q_nxt;
      s1_t_r     <= s0_t_r;
      s1_local_r <= s0_local_r;
      s1_fail_r  <= s0_fail_r;
    end
    if (en[2]) begin
      s2_days_r  <= s2_days_nxt;
      s2_rem_r   <= s2_rem_nxt;
      s2_local_r <= s1_local_r;
      s2_fail_r  <= s1_fail_r;
    end
  end

  assign out_item.days       = s2_days_r;
  assign out_item.rem        = s2_rem_r;
  assign out_item.local_mode = s2_local_r;
  assign out_item.fail       = s2_fail_r;

endmodule

/* src/ecal_fields.sv */
// Back five pipeline stages: year, month, day, weekday and clock fields from the
// day count and seconds of day. Depends on ecal_pkg.
module ecal_fields (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ecal_pkg::day_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ecal_pkg::result_t    out_result
);
  import ecal_pkg::*;

  logic [4:0] v_r;
  logic [4:0] en;

  // stage A: cycle-relative day, weekday operand
  logic [15:0] a_d_r, a_d_nxt, a_w_r, a_w_nxt;
  logic [16:0] a_rem_r;
  logic        a_adj_r, a_adj_nxt, a_local_r, a_fail_r;
  // stage B: approximate quotients
  logic [5:0]  b_cq_r, b_cq_nxt;
  logic [12:0] b_wq_r, b_wq_nxt;
  logic [4:0]  b_hq_r, b_hq_nxt;
  logic [15:0] b_d_r, b_w_r;
  logic [16:0] b_rem_r;
  logic        b_adj_r, b_local_r, b_fail_r;
  // stage C: corrected quotients and remainders
  logic [5:0]  c_cyc_r, c_cyc_nxt;
  logic [10:0] c_dc_r, c_dc_nxt;
  logic [2:0]  c_wd_r, c_wd_nxt;
  logic [4:0]  c_hour_r, c_hour_nxt;
  logic [11:0] c_hrem_r, c_hrem_nxt;
  logic        c_adj_r, c_local_r, c_fail_r;
  // stage D: year, virtual day of year, minute
  logic [7:0]  d_ys_r, d_ys_nxt;
  logic        d_leap_r, d_leap_nxt;
  logic [8:0]  d_vyd_r, d_vyd_nxt;
  logic [5:0]  d_min_r, d_min_nxt;
  logic [11:0] d_hrem_r;
  logic [2:0]  d_wd_r;
  logic [4:0]  d_hour_r;
  logic        d_adj_r, d_local_r, d_fail_r;
  // stage E: output register
  result_t     e_res_r, e_res_nxt;

  logic [29:0] prod_c, prod_h;
  logic [37:0] prod_w;
  logic [11:0] dc0;
  logic [3:0]  wd0;
  logic [12:0] hr0;
  logic [26:0] prod_m;
  logic [3:0]  mon;
  logic [8:0]  mstart;

  always_comb begin
    en[4] = !v_r[4] || out_ready;
    en[3] = !v_r[3] || en[4];
    en[2] = !v_r[2] || en[3];
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[4];

  // Move to cycles from 1968; past 2100-03-01 insert the missing Feb 29
  always_comb begin
    a_adj_nxt = in_item.days >= DAY_2100_MAR1;
    a_d_nxt   = in_item.days + EPOCH_TO_CYCLE_DAYS + 16'(a_adj_nxt);
    a_w_nxt   = in_item.days + EPOCH_WEEKDAY;
  end

  // Reciprocal multiplies, each may fall one short
  always_comb begin
    prod_c   = 30'(a_d_r) * 30'(CYCLE_RECIP);
    prod_w   = 38'(a_w_r) * 38'(WEEK_RECIP);
    prod_h   = 30'(a_rem_r) * 30'(HOUR_RECIP);
    b_cq_nxt = prod_c[29:24];
    b_wq_nxt = prod_w[36:24];
    b_hq_nxt = prod_h[28:24];
  end

  // Remainders with one correction step each
  always_comb begin
    dc0 = 12'(b_d_r - 16'(b_cq_r) * DAYS_PER_CYCLE);
    wd0 = 4'(b_w_r - 16'(b_wq_r) * DAYS_PER_WEEK);
    hr0 = 13'(b_rem_r - 17'(b_hq_r) * SECS_PER_HOUR);
    if (dc0 >= 12'(DAYS_PER_CYCLE)) begin
      c_cyc_nxt = b_cq_r + 6'd1;
      c_dc_nxt  = 11'(dc0 - 12'(DAYS_PER_CYCLE));
    end else begin
      c_cyc_nxt = b_cq_r;
      c_dc_nxt  = dc0[10:0];
    end
    if (wd0 >= 4'(DAYS_PER_WEEK)) begin
      c_wd_nxt = 3'(wd0 - 4'(DAYS_PER_WEEK));
    end else begin
      c_wd_nxt = wd0[2:0];
    end
    if (hr0 >= 13'(SECS_PER_HOUR)) begin
      c_hour_nxt = b_hq_r + 5'd1;
      c_hrem_nxt = 12'(hr0 - 13'(SECS_PER_HOUR));
    end else begin
      c_hour_nxt = b_hq_r;
      c_hrem_nxt = hr0[11:0];
    end
  end

  // Year within cycle (first is leap), minute by exact reciprocal
  always_comb begin
    logic [1:0] y;
    y = 2'd0;
    if (c_dc_r < 11'd366) begin
      y = 2'd0;
      d_vyd_nxt = 9'(c_dc_r);
    end else if (c_dc_r < 11'd731) begin
      y = 2'd1;
      d_vyd_nxt = 9'(c_dc_r - 11'd366);
    end else if (c_dc_r < 11'd1096) begin
      y = 2'd2;
      d_vyd_nxt = 9'(c_dc_r - 11'd731);
    end else begin
      y = 2'd3;
      d_vyd_nxt = 9'(c_dc_r - 11'd1096);
    end
    d_leap_nxt = (y == 2'd0);
    d_ys_nxt   = CYCLE_BASE_YEAR + {c_cyc_r, 2'b00} + 8'(y);
    prod_m     = 27'(c_hrem_r) * 27'(MIN_RECIP);
    d_min_nxt  = prod_m[25:20];
  end

  // Month by counting passed month starts; final result assembly
  always_comb begin
    mon = 4'd0;
    for (int m = 1; m < 12; m++) begin
      mon = mon + 4'(d_vyd_r >= month_start(4'(m), d_leap_r));
    end
    mstart = month_start(mon, d_leap_r);
    e_res_nxt = '0;
    if (!d_fail_r) begin
      e_res_nxt.ok               = 1'b1;
      e_res_nxt.dst_flag         = d_local_r;
      e_res_nxt.weekday          = d_wd_r;
      e_res_nxt.year_day         = d_vyd_r - 9'(d_adj_r && (d_ys_r == YEAR_2100));
      e_res_nxt.years_since_1900 = d_ys_r;
      e_res_nxt.month            = mon;
      e_res_nxt.month_day        = 5'(d_vyd_r - mstart + 9'd1);
      e_res_nxt.hour             = d_hour_r;
      e_res_nxt.minute           = d_min_r;
      e_res_nxt.second           = 6'(d_hrem_r - 12'(d_min_r) * SECS_PER_MIN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_d_r     <= a_d_nxt;
      a_w_r     <= a_w_nxt;
      a_rem_r   <= in_item.rem;
      a_adj_r   <= a_adj_nxt;
      a_local_r <= in_item.local_mode;
      a_fail_r  <= in_item.fail;
    end
    if (en[1]) begin
      b_cq_r    <= b_cq_nxt;
      b_wq_r    <= b_wq_nxt;
      b_hq_r    <= b_hq_nxt;
      b_d_r     <= a_d_r;
      b_w_r     <= a_w_r;
      b_rem_r   <= a_rem_r;
      b_adj_r   <= a_adj_r;
      b_local_r <= a_local_r;
      b_fail_r  <= a_fail_r;
    end
    if (en[2]) begin
      c_cyc_r   <= c_cyc_nxt;
      c_dc_r    <= c_dc_nxt;
      c_wd_r    <= c_wd_nxt;
      c_hour_r  <= c_hour_nxt;
      c_hrem_r  <= c_hrem_nxt;
      c_adj_r   <= b_adj_r;
      c_local_r <= b_local_r;
      c_fail_r  <= b_fail_r;
    end
    if (en[3]) begin
      d_ys_r    <= d_ys_nxt;
      d_leap_r  <= d_leap_nxt;
      d_vyd_r   <= d_vyd_nxt;
      d_min_r   <= d_min_nxt;
      d_hrem_r  <= c_hrem_r;
      d_wd_r    <= c_wd_r;
      d_hour_r  <= c_hour_r;
      d_adj_r   <= c_adj_r;
      d_local_r <= c_local_r;
      d_fail_r  <= c_fail_r;
    end
    if (en[4]) begin
      e_res_r <= e_res_nxt;
    end
  end

  assign out_result = e_res_r;

endmodule

/* src/epoch_seconds_to_calendar.sv */
// Epoch seconds to broken-down calendar time, eight register stages.
// Throughput: one item per cycle; each stage holds only while its successor is full.
// Reset (synchronous, rst_n low) empties the pipeline and clears all config registers.
// Depends on ecal_pkg, ecal_day_split and ecal_fields.
module epoch_seconds_to_calendar (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [31:0] epoch_seconds
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [5:0] second, [11:6] minute, [16:12] hour, [21:17] month_day, [25:22] month,
  // [33:26] years_since_1900, [42:34] year_day, [45:43] weekday, [46] dst_flag, [47] ok
  output logic [47:0]                     out_tdata,
  input  logic                            cfg_we,
  input  logic [ecal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecal_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ecal_pkg::*;

  logic        local_mode_r;
  logic [11:0] zone_offset_r;
  logic        zone_known_r;

  logic        mid_valid, mid_ready;
  day_item_t   mid_item;
  result_t     res;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mode_r  <= 1'b0;
      zone_offset_r <= '0;
      zone_known_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOCAL_MODE:  local_mode_r  <= cfg_wdata[0];
        REG_ZONE_OFFSET: zone_offset_r <= cfg_wdata[11:0];
        REG_ZONE_KNOWN:  zone_known_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ecal_day_split u_day_split (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_epoch    (in_tdata),
    .local_mode  (local_mode_r),
    .zone_offset (zone_offset_r),
    .zone_known  (zone_known_r),
    .out_valid   (mid_valid),
    .out_ready   (mid_ready),
    .out_item    (mid_item)
  );

  ecal_fields u_fields (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (mid_valid),
    .in_ready   (mid_ready),
    .in_item    (mid_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (res)
  );

  // Pack result fields, second in the low bits and ok in the top bit
  assign out_tdata = {res.ok, res.dst_flag, res.weekday, res.year_day, res.years_since_1900,
                      res.month, res.month_day, res.hour, res.minute, res.second};

endmodule
